[design/rtp_pkg.sv]
// shared types, constants and the distance table for the two-anchor position block
package rtp_pkg;

  localparam int FRAC_BITS_DEF = 8;
  localparam logic [6:0] REF_POWER_RESET = 7'd65;
  localparam logic [7:0] SPACING_RESET = 8'd2;
  localparam longint DEN_FIT = 158404;
  localparam longint LIN_FIT = 9154;
  localparam longint SQR_FIT = 265;
  localparam int DIST_W = 16;
  localparam int CFG_DATA_W = 8;

  typedef enum logic {
    CFG_REF_POWER = 1'b0,
    CFG_SPACING   = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic              seen_a;
    logic              seen_b;
    logic signed [7:0] q_a;
    logic signed [7:0] q_b;
    logic [7:0]        spacing;
  } item_t;

  typedef logic [DIST_W-1:0] dist_tab_t [256];

  function automatic dist_tab_t build_dist_tab(input int frac);
    dist_tab_t tab;
    longint q;
    longint num;
    longint v;
    for (int i = 0; i < 256; i++) begin
      q = (i < 128) ? longint'(i) : longint'(i) - 256;
      num = DEN_FIT + LIN_FIT * q + SQR_FIT * q * q;
      v = (num <<< frac) / DEN_FIT;
      if (v > 65535) v = 65535;
      tab[i] = v[DIST_W-1:0];
    end
    return tab;
  endfunction

endpackage

[design/rtp_if.sv]
// request and result channel interfaces
interface rtp_in_if;
  logic       valid;
  logic       ready;
  logic [6:0] rssi_a;
  logic [6:0] rssi_b;
  modport source(output valid, rssi_a, rssi_b, input ready);
  modport sink(input valid, rssi_a, rssi_b, output ready);
endinterface

interface rtp_out_if;
  logic               valid;
  logic               ready;
  logic [15:0]        dist_a;
  logic [15:0]        dist_b;
  logic signed [15:0] x_pos;
  logic [15:0]        y_pos;
  logic               position_valid;
  modport source(output valid, dist_a, dist_b, x_pos, y_pos, position_valid, input ready);
  modport sink(input valid, dist_a, dist_b, x_pos, y_pos, position_valid, output ready);
endinterface

[design/rssi_two_anchor_position.sv]
// top level of the two-anchor rssi position estimator
// channel | direction | payload
// in_chan | request   | rssi_a, rssi_b
// out_chan| result    | dist_a, dist_b, x_pos, y_pos, position_valid
// cfg_*   | write     | ref_power_1m (index 0), anchor_spacing (index 1)
// one request per cycle while no result is stalled; the back end holds the 16-stage divider
// and the 16-stage square root pipelines
// synchronous active-low reset clears all valid state and loads register defaults
// a stalled result holds the back pipeline; the two-entry queue keeps the front moving until it fills
module rssi_two_anchor_position #(
  parameter int FRAC_BITS = rtp_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [rtp_pkg::CFG_DATA_W-1:0] cfg_wdata,
  rtp_in_if.sink                         in_chan,
  rtp_out_if.source                      out_chan
);
  logic push, q_full, q_not_empty, pop;
  rtp_pkg::item_t f_item, q_item;

  rtp_front u_front (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(rtp_pkg::cfg_idx_t'(cfg_index)), .cfg_wdata(cfg_wdata),
    .req_valid(in_chan.valid), .req_ready(in_chan.ready),
    .rssi_a(in_chan.rssi_a), .rssi_b(in_chan.rssi_b),
    .push(push), .q_full(q_full), .item(f_item)
  );

  rtp_fifo u_fifo (
    .clk(clk), .rst_n(rst_n),
    .push(push), .wr_item(f_item), .full(q_full),
    .pop(pop), .not_empty(q_not_empty), .rd_item(q_item)
  );

  rtp_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_not_empty(q_not_empty), .q_item(q_item), .pop(pop),
    .res_valid(out_chan.valid), .res_ready(out_chan.ready),
    .dist_a(out_chan.dist_a), .dist_b(out_chan.dist_b),
    .x_pos(out_chan.x_pos), .y_pos(out_chan.y_pos),
    .position_valid(out_chan.position_valid)
  );
endmodule

[design/rtp_front.sv]
// front end: configuration registers, request capture and classification
module rtp_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  rtp_pkg::cfg_idx_t             cfg_index,
  input  logic [rtp_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  logic [6:0]                    rssi_a,
  input  logic [6:0]                    rssi_b,
  output logic                          push,
  input  logic                          q_full,
  output rtp_pkg::item_t                item
);
  logic [6:0] ref_r;
  logic [7:0] spacing_r;
  logic       f_valid_r;
  rtp_pkg::item_t f_item_r;
  rtp_pkg::item_t f_item_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r <= rtp_pkg::REF_POWER_RESET;
      spacing_r <= rtp_pkg::SPACING_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rtp_pkg::CFG_REF_POWER: ref_r <= cfg_wdata[6:0];
        rtp_pkg::CFG_SPACING:   spacing_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    f_item_nxt.seen_a = (rssi_a != 7'd0);
    f_item_nxt.seen_b = (rssi_b != 7'd0);
    f_item_nxt.q_a = $signed({1'b0, rssi_a}) - $signed({1'b0, ref_r});
    f_item_nxt.q_b = $signed({1'b0, rssi_b}) - $signed({1'b0, ref_r});
    f_item_nxt.spacing = spacing_r;
  end

  assign push = f_valid_r && !q_full;
  assign req_ready = !f_valid_r || !q_full;
  assign item = f_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else if (req_ready) begin
      f_valid_r <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready && req_valid) begin
      f_item_r <= f_item_nxt;
    end
  end
endmodule

[design/rtp_fifo.sv]
// two-entry queue between front end and back end
module rtp_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  rtp_pkg::item_t wr_item,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output rtp_pkg::item_t rd_item
);
  rtp_pkg::item_t mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;

  assign full = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign rd_item = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop) rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_item;
  end
endmodule

[design/rtp_back.sv]
// back end: distance lookup, law of cosines, divider and square root pipelines
module rtp_back #(
  parameter int FRAC_BITS = rtp_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_not_empty,
  input  rtp_pkg::item_t     q_item,
  output logic               pop,
  output logic               res_valid,
  input  logic               res_ready,
  output logic [15:0]        dist_a,
  output logic [15:0]        dist_b,
  output logic signed [15:0] x_pos,
  output logic [15:0]        y_pos,
  output logic               position_valid
);
  localparam int F = FRAC_BITS;
  localparam int W = 2 * F + 26;
  localparam int NDIV = 16;
  localparam rtp_pkg::dist_tab_t DIST_TAB = rtp_pkg::build_dist_tab(FRAC_BITS);

  logic adv;
  logic out_v_r;
  assign adv = !out_v_r || res_ready;
  assign pop = adv && q_not_empty;

  // lookup
  logic        v1_r;
  logic [15:0] da1_r, db1_r;
  logic [7:0]  sp1_r;
  // products
  logic        v2_r, ok2_r;
  logic [15:0] da2_r, db2_r;
  logic [31:0] daa2_r, dbb2_r;
  logic [15:0] spsq2_r;
  logic [23:0] dasp2_r;
  logic [7:0]  sp2_r;
  // numerator and limit
  logic                v3_r, ok3_r;
  logic [15:0]         da3_r, db3_r;
  logic [31:0]         daa3_r;
  logic [7:0]          sp3_r;
  logic signed [W-1:0] num3_r;
  logic [W-1:0]        lim3_r;
  logic signed [W-1:0] num_nxt;
  logic [W-1:0]        lim_nxt;
  logic [W-1:0]        mag;
  logic                good_nxt;

  // divider stages
  logic        dv_r   [0:NDIV];
  logic        dg_r   [0:NDIV];
  logic        dn_r   [0:NDIV];
  logic [15:0] dda_r  [0:NDIV];
  logic [15:0] ddb_r  [0:NDIV];
  logic [31:0] ddaa_r [0:NDIV];
  logic [7:0]  dsp_r  [0:NDIV];
  logic [23:0] drem_r [0:NDIV];
  logic [15:0] dq_r   [0:NDIV];
  logic [23:0] drem_nxt [0:NDIV-1];
  logic [15:0] dq_nxt   [0:NDIV-1];

  // square and radicand
  logic               v21_r, g21_r;
  logic [15:0]        da21_r, db21_r;
  logic [31:0]        daa21_r, xsq21_r;
  logic signed [15:0] x21_r;
  logic signed [15:0] xsat_nxt;

  // sqrt stages
  logic               sv_r   [0:NDIV];
  logic               sg_r   [0:NDIV];
  logic [15:0]        sda_r  [0:NDIV];
  logic [15:0]        sdb_r  [0:NDIV];
  logic signed [15:0] sx_r   [0:NDIV];
  logic [31:0]        sval_r [0:NDIV];
  logic [18:0]        srem_r [0:NDIV];
  logic [15:0]        sroot_r[0:NDIV];
  logic [18:0]        srem_nxt [0:NDIV-1];
  logic [15:0]        sroot_nxt[0:NDIV-1];

  logic [15:0]        oda_r, odb_r, oy_r;
  logic signed [15:0] ox_r;
  logic               opv_r;

  always_comb begin
    num_nxt = $signed({{(W-32){1'b0}}, daa2_r})
            + ($signed({{(W-16){1'b0}}, spsq2_r}) <<< (2 * F))
            - $signed({{(W-32){1'b0}}, dbb2_r});
    lim_nxt = {{(W-24){1'b0}}, dasp2_r} << (F + 1);
    mag = num3_r[W-1] ? W'(-num3_r) : W'(num3_r);
    good_nxt = ok3_r && (mag <= lim3_r);
  end

  always_comb begin
    for (int k = 0; k < NDIV; k++) begin
      if (drem_r[k] >= ({16'd0, dsp_r[k]} << (NDIV - 1 - k))) begin
        drem_nxt[k] = drem_r[k] - ({16'd0, dsp_r[k]} << (NDIV - 1 - k));
        dq_nxt[k] = dq_r[k] | (16'd1 << (NDIV - 1 - k));
      end else begin
        drem_nxt[k] = drem_r[k];
        dq_nxt[k] = dq_r[k];
      end
    end
  end

  always_comb begin
    if (!dn_r[NDIV]) begin
      xsat_nxt = (dq_r[NDIV] > 16'd32767) ? 16'sd32767 : $signed(dq_r[NDIV]);
    end else begin
      xsat_nxt = (dq_r[NDIV] >= 16'd32768) ? -16'sd32768 : -$signed(dq_r[NDIV]);
    end
  end

  always_comb begin
    for (int k = 0; k < NDIV; k++) begin
      if ({srem_r[k][16:0], sval_r[k][31:30]} >= {1'b0, sroot_r[k], 2'b01}) begin
        srem_nxt[k] = {srem_r[k][16:0], sval_r[k][31:30]} - {1'b0, sroot_r[k], 2'b01};
        sroot_nxt[k] = {sroot_r[k][14:0], 1'b1};
      end else begin
        srem_nxt[k] = {srem_r[k][16:0], sval_r[k][31:30]};
        sroot_nxt[k] = {sroot_r[k][14:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v21_r <= 1'b0;
      out_v_r <= 1'b0;
      for (int k = 0; k <= NDIV; k++) begin
        dv_r[k] <= 1'b0;
        sv_r[k] <= 1'b0;
      end
    end else if (adv) begin
      v1_r <= q_not_empty;
      v2_r <= v1_r;
      v3_r <= v2_r;
      dv_r[0] <= v3_r;
      for (int k = 0; k < NDIV; k++) dv_r[k+1] <= dv_r[k];
      v21_r <= dv_r[NDIV];
      sv_r[0] <= v21_r;
      for (int k = 0; k < NDIV; k++) sv_r[k+1] <= sv_r[k];
      out_v_r <= sv_r[NDIV];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      da1_r <= q_item.seen_a ? DIST_TAB[$unsigned(q_item.q_a)] : 16'd0;
      db1_r <= q_item.seen_b ? DIST_TAB[$unsigned(q_item.q_b)] : 16'd0;
      sp1_r <= q_item.spacing;

      da2_r <= da1_r;
      db2_r <= db1_r;
      sp2_r <= sp1_r;
      daa2_r <= da1_r * da1_r;
      dbb2_r <= db1_r * db1_r;
      spsq2_r <= sp1_r * sp1_r;
      dasp2_r <= da1_r * sp1_r;
      ok2_r <= (da1_r != 16'd0) && (db1_r != 16'd0) && (sp1_r != 8'd0);

      da3_r <= da2_r;
      db3_r <= db2_r;
      daa3_r <= daa2_r;
      sp3_r <= sp2_r;
      ok3_r <= ok2_r;
      num3_r <= num_nxt;
      lim3_r <= lim_nxt;

      dg_r[0] <= good_nxt;
      dn_r[0] <= num3_r[W-1];
      dda_r[0] <= da3_r;
      ddb_r[0] <= db3_r;
      ddaa_r[0] <= daa3_r;
      dsp_r[0] <= sp3_r;
      drem_r[0] <= good_nxt ? 24'(mag >> (F + 1)) : 24'd0;
      dq_r[0] <= 16'd0;
      for (int k = 0; k < NDIV; k++) begin
        dg_r[k+1] <= dg_r[k];
        dn_r[k+1] <= dn_r[k];
        dda_r[k+1] <= dda_r[k];
        ddb_r[k+1] <= ddb_r[k];
        ddaa_r[k+1] <= ddaa_r[k];
        dsp_r[k+1] <= dsp_r[k];
        drem_r[k+1] <= drem_nxt[k];
        dq_r[k+1] <= dq_nxt[k];
      end

      g21_r <= dg_r[NDIV];
      da21_r <= dda_r[NDIV];
      db21_r <= ddb_r[NDIV];
      daa21_r <= ddaa_r[NDIV];
      xsq21_r <= dq_r[NDIV] * dq_r[NDIV];
      x21_r <= dg_r[NDIV] ? xsat_nxt : 16'sd0;

      sg_r[0] <= g21_r;
      sda_r[0] <= da21_r;
      sdb_r[0] <= db21_r;
      sx_r[0] <= x21_r;
      sval_r[0] <= g21_r ? (daa21_r - xsq21_r) : 32'd0;
      srem_r[0] <= 19'd0;
      sroot_r[0] <= 16'd0;
      for (int k = 0; k < NDIV; k++) begin
        sg_r[k+1] <= sg_r[k];
        sda_r[k+1] <= sda_r[k];
        sdb_r[k+1] <= sdb_r[k];
        sx_r[k+1] <= sx_r[k];
        sval_r[k+1] <= {sval_r[k][29:0], 2'b00};
        srem_r[k+1] <= srem_nxt[k];
        sroot_r[k+1] <= sroot_nxt[k];
      end

      oda_r <= sda_r[NDIV];
      odb_r <= sdb_r[NDIV];
      ox_r <= sx_r[NDIV];
      oy_r <= sroot_r[NDIV];
      opv_r <= sg_r[NDIV];
    end
  end

  assign res_valid = out_v_r;
  assign dist_a = oda_r;
  assign dist_b = odb_r;
  assign x_pos = ox_r;
  assign y_pos = oy_r;
  assign position_valid = opv_r;
endmodule

[design/rtp_checker.sv]
// port-level checks on the result channel, bound to the top level
module rtp_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [15:0]        dist_a,
  input logic [15:0]        dist_b,
  input logic signed [15:0] x_pos,
  input logic [15:0]        y_pos,
  input logic               position_valid
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_pos_needs_dist: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && position_valid |-> dist_a != 16'd0 && dist_b != 16'd0)
    else $error("position with absent beacon");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !position_valid |-> x_pos == 16'sd0 && y_pos == 16'd0)
    else $error("nonzero position when invalid");

  a_y_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && position_valid |-> y_pos <= dist_a)
    else $error("y exceeds distance to beacon a");
endmodule

bind rssi_two_anchor_position rtp_checker u_rtp_checker (
  .clk(clk), .rst_n(rst_n),
  .out_valid(out_chan.valid), .out_ready(out_chan.ready),
  .dist_a(out_chan.dist_a), .dist_b(out_chan.dist_b),
  .x_pos(out_chan.x_pos), .y_pos(out_chan.y_pos),
  .position_valid(out_chan.position_valid)
);

[sim/rssi_two_anchor_position_tb.sv]
// testbench for the two-anchor rssi position estimator
`timescale 1ns / 1ps

module rssi_two_anchor_position_tb;

  localparam int FRAC = rtp_pkg::FRAC_BITS_DEF;
  localparam int DRAIN_CYCLES = 100;
  localparam longint CYCLE_LIMIT = 600000;

  typedef struct {
    logic [15:0]        dist_a;
    logic [15:0]        dist_b;
    logic signed [15:0] x_pos;
    logic [15:0]        y_pos;
    logic               position_valid;
  } fix_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  rtp_pkg::cfg_idx_t cfg_index;
  logic [rtp_pkg::CFG_DATA_W-1:0] cfg_wdata;

  rtp_in_if in_if ();
  rtp_out_if out_if ();

  rssi_two_anchor_position DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  logic [6:0] ref_level;
  logic [7:0] spacing_m;
  fix_t pending_fixes[$];
  int errors;
  int tx_idle_pct;
  int rx_idle_pct;
  int rx_hold;
  longint cycles;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r = 0;
    longint unsigned b = 64'h4000_0000_0000_0000;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint range_from_rssi(logic [6:0] rssi, logic [6:0] lvl);
    longint q;
    longint num;
    longint v;
    if (rssi == 0) return 0;
    q = longint'(rssi) - longint'(lvl);
    num = rtp_pkg::DEN_FIT + rtp_pkg::LIN_FIT * q + rtp_pkg::SQR_FIT * q * q;
    v = (num * (longint'(1) << FRAC)) / rtp_pkg::DEN_FIT;
    if (v > 65535) v = 65535;
    return v;
  endfunction

  function automatic fix_t locate(logic [6:0] ra, logic [6:0] rb);
    fix_t f;
    longint da;
    longint db;
    longint a;
    longint num;
    longint lim;
    longint mag;
    longint xr;
    da = range_from_rssi(ra, ref_level);
    db = range_from_rssi(rb, ref_level);
    f.dist_a = da[15:0];
    f.dist_b = db[15:0];
    f.x_pos = '0;
    f.y_pos = '0;
    f.position_valid = 1'b0;
    if (da != 0 && db != 0 && spacing_m != 0) begin
      a = longint'(spacing_m) * (longint'(1) << FRAC);
      num = da * da + a * a - db * db;
      lim = 2 * da * a;
      mag = num < 0 ? -num : num;
      if (mag <= lim) begin
        xr = num / (2 * a);
        f.y_pos = 16'(root_floor(longint'(da * da - xr * xr)));
        if (xr > 32767) xr = 32767;
        if (xr < -32768) xr = -32768;
        f.x_pos = xr[15:0];
        f.position_valid = 1'b1;
      end
    end
    return f;
  endfunction

  // receiver: random stalls plus a long hold-off when requested
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    fix_t e;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("rssi_two_anchor_position test failed");
      $finish;
    end
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_fixes.size() == 0) begin
        $display("%0t: unexpected result dist_a=%h dist_b=%h x=%h y=%h valid=%b", $time,
                 out_if.dist_a, out_if.dist_b, out_if.x_pos, out_if.y_pos,
                 out_if.position_valid);
        errors++;
      end else begin
        e = pending_fixes.pop_front();
        if (out_if.dist_a !== e.dist_a) begin
          $display("%0t: dist_a expected %h actual %h", $time, e.dist_a, out_if.dist_a);
          errors++;
        end
        if (out_if.dist_b !== e.dist_b) begin
          $display("%0t: dist_b expected %h actual %h", $time, e.dist_b, out_if.dist_b);
          errors++;
        end
        if (out_if.x_pos !== e.x_pos) begin
          $display("%0t: x_pos expected %h actual %h", $time, e.x_pos, out_if.x_pos);
          errors++;
        end
        if (out_if.y_pos !== e.y_pos) begin
          $display("%0t: y_pos expected %h actual %h", $time, e.y_pos, out_if.y_pos);
          errors++;
        end
        if (out_if.position_valid !== e.position_valid) begin
          $display("%0t: position_valid expected %b actual %b", $time, e.position_valid,
                   out_if.position_valid);
          errors++;
        end
      end
    end
  end

  // ready only changes after a rising edge, so its value at the falling edge holds at the next one
  task automatic send_request(logic [6:0] ra, logic [6:0] rb);
    @(negedge clk);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_if.valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_if.valid = 1'b1;
    in_if.rssi_a = ra;
    in_if.rssi_b = rb;
    while (!in_if.ready) @(negedge clk);
    @(posedge clk);
    pending_fixes.push_back(locate(ra, rb));
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_if.valid = 1'b0;
    while (pending_fixes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(rtp_pkg::cfg_idx_t idx, logic [7:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == rtp_pkg::CFG_REF_POWER) ref_level = val[6:0];
    else spacing_m = val;
  endtask

  function automatic logic [6:0] pick_rssi();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 7'd0;
    if (r < 18) return 7'($urandom_range(0, 127));
    // mostly near the reference so positions come out valid
    return 7'($urandom_range(ref_level > 20 ? ref_level - 20 : 1,
                             ref_level < 87 ? ref_level + 20 : 107));
  endfunction

  task automatic test_directed();
    send_request(7'd0, 7'd0);
    send_request(7'd0, 7'd50);
    send_request(7'd50, 7'd0);
    send_request(7'd65, 7'd65);
    send_request(7'd1, 7'd1);
    send_request(7'd99, 7'd99);
    send_request(7'd127, 7'd127);
    send_request(7'd1, 7'd127);
    send_request(7'd127, 7'd1);
    send_request(7'd99, 7'd1);
    send_request(7'd1, 7'd99);
    send_request(7'd65, 7'd99);
    send_request(7'd99, 7'd65);
    send_request(7'd70, 7'd60);
    send_request(7'd85, 7'd42);
    wait_idle();
    write_register(rtp_pkg::CFG_SPACING, 8'd0);
    send_request(7'd65, 7'd65);
    send_request(7'd70, 7'd72);
    wait_idle();
    write_register(rtp_pkg::CFG_REF_POWER, 8'd127);
    write_register(rtp_pkg::CFG_SPACING, 8'd255);
    send_request(7'd0, 7'd127);
    send_request(7'd127, 7'd1);
    send_request(7'd1, 7'd1);
    send_request(7'd100, 7'd120);
    wait_idle();
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        wait_idle();
        case ($urandom_range(0, 5))
          0: begin
            write_register(rtp_pkg::CFG_REF_POWER, 8'd0);
            write_register(rtp_pkg::CFG_SPACING, 8'd1);
          end
          1: begin
            write_register(rtp_pkg::CFG_REF_POWER, 8'd99);
            write_register(rtp_pkg::CFG_SPACING, 8'd255);
          end
          2: begin
            write_register(rtp_pkg::CFG_REF_POWER, 8'($urandom_range(0, 127)));
            write_register(rtp_pkg::CFG_SPACING, 8'($urandom_range(0, 255)));
          end
          default: begin
            write_register(rtp_pkg::CFG_REF_POWER, 8'($urandom_range(40, 80)));
            write_register(rtp_pkg::CFG_SPACING, 8'($urandom_range(1, 6)));
          end
        endcase
      end
      send_request(pick_rssi(), pick_rssi());
    end
    wait_idle();
  endtask

  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_hold = 300;
    for (int i = 0; i < 60; i++) send_request(pick_rssi(), pick_rssi());
    wait_idle();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = rtp_pkg::CFG_REF_POWER;
    cfg_wdata = '0;
    in_if.valid = 1'b0;
    in_if.rssi_a = '0;
    in_if.rssi_b = '0;
    out_if.ready = 1'b0;
    errors = 0;
    cycles = 0;
    rx_hold = 0;
    ref_level = rtp_pkg::REF_POWER_RESET;
    spacing_m = rtp_pkg::SPACING_RESET;
    tx_idle_pct = 31;
    rx_idle_pct = 49;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random(220);
    tx_idle_pct = 49;
    rx_idle_pct = 31;
    test_random(220);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random(220);
    test_backpressure();

    if (errors == 0) begin
      $display("rssi_two_anchor_position test passed");
    end else begin
      $display("rssi_two_anchor_position test failed");
    end
    $finish;
  end

endmodule

[sim.f]
design/rtp_pkg.sv
design/rtp_if.sv
design/rtp_front.sv
design/rtp_fifo.sv
design/rtp_back.sv
design/rssi_two_anchor_position.sv
design/rtp_checker.sv
sim/rssi_two_anchor_position_tb.sv
